// ===== hdl/lhd_pkg.sv =====
// Shared types, constants and the microcode ROM for the letter histogram distance block.
`timescale 1ns / 1ps

package lhd_pkg;

	localparam int LETTER_W = 5;
	localparam int CHANGE_W = 13;
	localparam logic [CHANGE_W-1:0] COUNT_MAX = 13'h1FFF;
	localparam int STEP_W = 3;

	// which address feeds the balance store
	typedef enum logic [1:0] {
		SEL_A,
		SEL_B,
		SEL_IDX
	} addr_sel_t;

	// jump condition, taken when true, else fall through
	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_START,
		COND_NOT_LAST,
		COND_MORE
	} cond_t;

	typedef logic [STEP_W-1:0] step_t;

	typedef struct packed {
		logic      busy;
		logic      latch;
		addr_sel_t addr_sel;
		logic      wr_en;
		logic      wr_up;
		logic      acc_clr;
		logic      acc_add;
		logic      emit;
		cond_t     cond;
		step_t     target;
	} ctrl_t;

	localparam step_t STEP_WAIT   = 3'd0;
	localparam step_t STEP_RD_A   = 3'd1;
	localparam step_t STEP_WR_A   = 3'd2;
	localparam step_t STEP_RD_B   = 3'd3;
	localparam step_t STEP_WR_B   = 3'd4;
	localparam step_t STEP_SUM_RD = 3'd5;
	localparam step_t STEP_SUM_AC = 3'd6;
	localparam step_t STEP_EMIT   = 3'd7;

	// microcode ROM: one control word per step
	function automatic ctrl_t ucode(input step_t step);
		ctrl_t cw;
		cw = '{busy: 1'b1, latch: 1'b0, addr_sel: SEL_A, wr_en: 1'b0, wr_up: 1'b0,
			acc_clr: 1'b0, acc_add: 1'b0, emit: 1'b0, cond: COND_NEVER,
			target: STEP_WAIT};
		case (step)
			STEP_WAIT: begin
				cw.busy    = 1'b0;
				cw.latch   = 1'b1;
				cw.acc_clr = 1'b1;
				cw.cond    = COND_NO_START;
				cw.target  = STEP_WAIT;
			end
			STEP_RD_A: begin
				cw.addr_sel = SEL_A;
			end
			STEP_WR_A: begin
				cw.addr_sel = SEL_A;
				cw.wr_en    = 1'b1;
				cw.wr_up    = 1'b1;
			end
			STEP_RD_B: begin
				cw.addr_sel = SEL_B;
			end
			STEP_WR_B: begin
				cw.addr_sel = SEL_B;
				cw.wr_en    = 1'b1;
				cw.cond     = COND_NOT_LAST;
				cw.target   = STEP_WAIT;
			end
			STEP_SUM_RD: begin
				cw.addr_sel = SEL_IDX;
			end
			STEP_SUM_AC: begin
				cw.addr_sel = SEL_IDX;
				cw.acc_add  = 1'b1;
				cw.cond     = COND_MORE;
				cw.target   = STEP_SUM_RD;
			end
			STEP_EMIT: begin
				cw.emit   = 1'b1;
				cw.cond   = COND_ALWAYS;
				cw.target = STEP_WAIT;
			end
			default: begin
				cw.cond   = COND_ALWAYS;
				cw.target = STEP_WAIT;
			end
		endcase
		return cw;
	endfunction

endpackage

// ===== hdl/lhd_seq.sv =====
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
`timescale 1ns / 1ps

module lhd_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           last,
	input  logic           more,
	output lhd_pkg::ctrl_t cw
);

	lhd_pkg::step_t step_q;
	logic           take;

	assign cw = lhd_pkg::ucode(step_q);

	always_comb begin
		case (cw.cond)
			lhd_pkg::COND_NEVER:    take = 1'b0;
			lhd_pkg::COND_ALWAYS:   take = 1'b1;
			lhd_pkg::COND_NO_START: take = !start;
			lhd_pkg::COND_NOT_LAST: take = !last;
			lhd_pkg::COND_MORE:     take = more;
			default:                take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= lhd_pkg::STEP_WAIT;
		end else if (take) begin
			step_q <= cw.target;
		end else begin
			step_q <= step_q + lhd_pkg::step_t'(1);
		end
	end

endmodule

// ===== hdl/letter_histogram_distance_top.sv =====
// Top level: letter balance store, datapath and result register of the histogram distance.
`timescale 1ns / 1ps

// channel  | ports                                   | handshake
// ---------+-----------------------------------------+-------------------------------
// item in  | letter_first, letter_second, run_end    | taken when start & !busy
// result   | change_count                            | valid while done, one cycle
//
// A pair runs through the accept step, then read/update of the first
// letter's counter and read/update of the second's through one store port.
// A pair with run_end adds a drain (read and add per counter, then emit);
// done is registered from the emit step.
// Reset clears the sequencer and the per-counter valid bits, so the store
// reads as all zero at once: no clearing pass. The receiver cannot stall.

module letter_histogram_distance_top #(
	parameter int MAX_RUN       = 4096,
	parameter int ALPHABET_SIZE = 26
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [lhd_pkg::LETTER_W-1:0]  letter_first,
	input  logic [lhd_pkg::LETTER_W-1:0]  letter_second,
	input  logic                          run_end,
	output logic                          done,
	output logic [lhd_pkg::CHANGE_W-1:0]  change_count
);

	// counter holds -MAX_RUN..+MAX_RUN
	localparam int MAG_W  = $clog2(MAX_RUN + 1);
	localparam int CNT_W  = MAG_W + 1;
	localparam int ADDR_W = $clog2(ALPHABET_SIZE);
	localparam int SUM_W  = MAG_W + $clog2(ALPHABET_SIZE + 1);
	localparam logic signed [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RUN);
	localparam logic signed [CNT_W-1:0] CNT_MIN = -CNT_MAX;
	localparam logic [ADDR_W-1:0] IDX_LAST = ADDR_W'(ALPHABET_SIZE - 1);

	lhd_pkg::ctrl_t cw;

	// latched item
	logic [ADDR_W-1:0] a_idx_q, b_idx_q;
	logic              a_ok_q, b_ok_q, last_q;
	logic [31:0]       first_w, second_w;

	// balance store with per-entry valid bits
	logic signed [CNT_W-1:0] mem [ALPHABET_SIZE];
	logic [ALPHABET_SIZE-1:0] vld_q;
	logic signed [CNT_W-1:0] rd_q;
	logic                    rd_vld_q;
	logic signed [CNT_W-1:0] rd_val, wr_val, neg_val;
	logic [MAG_W-1:0]        mag;
	logic [ADDR_W-1:0]       addr;
	logic                    wr_ok;

	// drain
	logic [ADDR_W-1:0] idx_q;
	logic [SUM_W-1:0]  acc_q, half;
	logic              more;

	lhd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (last_q),
		.more   (more),
		.cw     (cw)
	);

	assign busy     = cw.busy;
	assign first_w  = 32'(letter_first);
	assign second_w = 32'(letter_second);
	assign more     = (idx_q != IDX_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_ok_q <= 1'b0;
			b_ok_q <= 1'b0;
			last_q <= 1'b0;
		end else if (cw.latch && start) begin
			// letters beyond the alphabet touch no counter
			a_ok_q <= (first_w < 32'(ALPHABET_SIZE));
			b_ok_q <= (second_w < 32'(ALPHABET_SIZE));
			last_q <= run_end;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.latch && start) begin
			a_idx_q <= first_w[ADDR_W-1:0];
			b_idx_q <= second_w[ADDR_W-1:0];
		end
	end

	always_comb begin
		case (cw.addr_sel)
			lhd_pkg::SEL_A:   addr = a_idx_q;
			lhd_pkg::SEL_B:   addr = b_idx_q;
			lhd_pkg::SEL_IDX: addr = idx_q;
			default:          addr = '0;
		endcase
	end

	assign wr_ok  = cw.wr_en && ((cw.addr_sel == lhd_pkg::SEL_A) ? a_ok_q : b_ok_q);
	assign rd_val = rd_vld_q ? rd_q : '0;

	// saturating step up or down
	always_comb begin
		if (cw.wr_up) begin
			wr_val = (rd_val < CNT_MAX) ? rd_val + CNT_W'(1) : rd_val;
		end else begin
			wr_val = (rd_val > CNT_MIN) ? rd_val - CNT_W'(1) : rd_val;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[addr] <= wr_val;
		end
		rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[addr];
			if (cw.emit) begin
				vld_q <= '0;
			end else if (wr_ok) begin
				vld_q[addr] <= 1'b1;
			end
		end
	end

	// absolute value of the counter just read
	assign neg_val = -rd_val;
	assign mag     = rd_val[CNT_W-1] ? neg_val[MAG_W-1:0] : rd_val[MAG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			acc_q <= '0;
		end else if (cw.acc_clr) begin
			idx_q <= '0;
			acc_q <= '0;
		end else if (cw.acc_add) begin
			idx_q <= idx_q + ADDR_W'(1);
			acc_q <= acc_q + SUM_W'(mag);
		end
	end

	assign half = acc_q >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cw.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.emit) begin
			if (32'(half) > 32'(lhd_pkg::COUNT_MAX)) begin
				change_count <= lhd_pkg::COUNT_MAX;
			end else begin
				change_count <= lhd_pkg::CHANGE_W'(half);
			end
		end
	end

endmodule

// ===== hdl/lhd_chk.sv =====
// Port-level checker for the histogram distance block, bound to the top level.
`timescale 1ns / 1ps

module lhd_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [lhd_pkg::CHANGE_W-1:0] change_count
);

	// a result is a single-cycle strobe
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held for more than one cycle");

	// a result only follows a busy drain
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without preceding work");

	// the block is free again when the result shows
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy while result shown");

	// each item keeps the block busy while it reads and updates the store
	a_item_len: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy ##1 busy ##1 busy ##1 busy)
		else $error("item finished too early");

	// a shown result is always a known value
	a_count_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(change_count))
		else $error("change_count unknown while done");

endmodule

bind letter_histogram_distance_top lhd_chk u_lhd_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.change_count (change_count)
);
